@@ rtl/xda_pkg.sv @@
package xda_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_LOAD_ROW   = 3'd0;
  localparam logic [2:0] OP_LOAD_COL   = 3'd1;
  localparam logic [2:0] OP_WRITE_CELL = 3'd2;
  localparam logic [2:0] OP_RUN        = 3'd3;
  localparam logic [2:0] OP_READ_CELL  = 3'd4;

  // register indexes on the configuration port
  localparam logic [1:0] REG_ROW_LEN = 2'd0;
  localparam logic [1:0] REG_COL_LEN = 2'd1;
  localparam logic [1:0] REG_X_THR   = 2'd2;

  localparam logic [6:0]  ROW_LEN_RESET = 7'd64;
  localparam logic [6:0]  COL_LEN_RESET = 7'd64;
  localparam logic [14:0] X_THR_RESET   = 15'd10;

  // result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic signed [15:0] PRUNED_MARK = 16'sh8000;
  localparam logic signed [17:0] SCORE_HI    = 18'sd32767;
  localparam logic signed [17:0] SCORE_LO    = -18'sd32767;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_READ_RESP,
    CMD_INIT,
    CMD_AD_CHECK,
    CMD_CELL_CHECK,
    CMD_RD_D,
    CMD_RD_L,
    CMD_RD_U,
    CMD_CELL_WR,
    CMD_PRUNE_RD,
    CMD_PRUNE_EV,
    CMD_TRIM,
    CMD_FINISH
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t cmd;
    logic   stopped;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ad_done;
    logic band_empty;
    logic at_end;
    logic boundary;
  } dp_status_t;

endpackage

@@ rtl/xda_ram.sv @@
module xda_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/xda_ctrl.sv @@
module xda_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  host_accept,
  input  logic [2:0]            host_op,
  input  xda_pkg::dp_status_t   status,
  output xda_pkg::ctrl_cmd_t    cmd,
  output logic                  idle
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_INIT,
    S_AD,
    S_CELL,
    S_RD_D,
    S_RD_L,
    S_RD_U,
    S_WR,
    S_PRUNE_RD,
    S_PRUNE_EV,
    S_TRIM,
    S_FIN_FULL,
    S_FIN_STOP
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (host_accept && host_op == xda_pkg::OP_RUN) begin
            state_r <= S_INIT;
          end else if (host_accept && host_op == xda_pkg::OP_READ_CELL) begin
            state_r <= S_READ;
          end
        end
        S_READ:  state_r <= S_IDLE;
        S_INIT:  state_r <= S_AD;
        S_AD: begin
          if (status.ad_done) begin
            state_r <= S_FIN_FULL;
          end else if (status.band_empty) begin
            state_r <= S_FIN_STOP;
          end else begin
            state_r <= S_CELL;
          end
        end
        S_CELL: begin
          if (status.at_end) begin
            state_r <= S_PRUNE_RD;
          end else if (!status.boundary) begin
            state_r <= S_RD_D;
          end
        end
        S_RD_D:  state_r <= S_RD_L;
        S_RD_L:  state_r <= S_RD_U;
        S_RD_U:  state_r <= S_WR;
        S_WR:    state_r <= S_CELL;
        S_PRUNE_RD: begin
          if (status.at_end) begin
            state_r <= S_TRIM;
          end else begin
            state_r <= S_PRUNE_EV;
          end
        end
        S_PRUNE_EV: state_r <= S_PRUNE_RD;
        S_TRIM:     state_r <= S_AD;
        S_FIN_FULL: state_r <= S_IDLE;
        S_FIN_STOP: state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.stopped = 1'b0;
    case (state_r)
      S_READ:     cmd.cmd = xda_pkg::CMD_READ_RESP;
      S_INIT:     cmd.cmd = xda_pkg::CMD_INIT;
      S_AD:       cmd.cmd = xda_pkg::CMD_AD_CHECK;
      S_CELL:     cmd.cmd = xda_pkg::CMD_CELL_CHECK;
      S_RD_D:     cmd.cmd = xda_pkg::CMD_RD_D;
      S_RD_L:     cmd.cmd = xda_pkg::CMD_RD_L;
      S_RD_U:     cmd.cmd = xda_pkg::CMD_RD_U;
      S_WR:       cmd.cmd = xda_pkg::CMD_CELL_WR;
      S_PRUNE_RD: cmd.cmd = xda_pkg::CMD_PRUNE_RD;
      S_PRUNE_EV: cmd.cmd = xda_pkg::CMD_PRUNE_EV;
      S_TRIM:     cmd.cmd = xda_pkg::CMD_TRIM;
      S_FIN_FULL: cmd.cmd = xda_pkg::CMD_FINISH;
      S_FIN_STOP: begin
        cmd.cmd     = xda_pkg::CMD_FINISH;
        cmd.stopped = 1'b1;
      end
      default:    cmd.cmd = xda_pkg::CMD_NONE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

endmodule

@@ rtl/xda_dp.sv @@
module xda_dp #(
  parameter int MAX_LEN = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xda_pkg::ctrl_cmd_t    cmd,
  output xda_pkg::dp_status_t   status,
  input  logic                  host_accept,
  input  logic [2:0]            host_op,
  input  logic [6:0]            host_row,
  input  logic [6:0]            host_col,
  input  logic [7:0]            host_symbol,
  input  logic signed [15:0]    host_value,
  input  logic [6:0]            row_length,
  input  logic [6:0]            col_length,
  input  logic [14:0]           x_threshold,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_kind,
  output logic signed [15:0]    out_score,
  output logic                  out_pruned,
  output logic signed [15:0]    out_best,
  output logic                  out_stopped
);

  localparam int DIM = MAX_LEN + 1;
  localparam int IW  = $clog2(DIM);
  localparam int SYW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int MW  = $clog2(DIM * DIM);
  localparam int AW  = $clog2(2 * MAX_LEN + 2);
  localparam int SW  = AW + 2;
  localparam logic signed [SW-1:0] ONE  = SW'(1);
  localparam logic signed [SW-1:0] TWO  = SW'(2);
  localparam logic signed [SW-1:0] ZERO = '0;

  function automatic logic [MW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return MW'(r) * MW'(DIM) + MW'(c);
  endfunction

  function automatic logic signed [SW-1:0] len_eff(input logic [6:0] v);
    logic signed [SW-1:0] res;
    if (v == 7'd0) begin
      res = ONE;
    end else if (32'(v) > 32'(MAX_LEN)) begin
      res = SW'(MAX_LEN);
    end else begin
      res = SW'($signed({1'b0, v}));
    end
    return res;
  endfunction

  // sweep registers
  logic signed [SW-1:0] ad_r, bs_r, be_r, i_r, lo_r, up_r, f_r, lnp_r;
  logic                 lo_b_r, up_b_r, found_r, rd_ok_r;
  logic signed [15:0]   rb_r, d_r, l_r;

  logic signed [SW-1:0] rr, cc, j_s, be_n, bs_n, adl;
  logic [IW-1:0]        ci, cj;
  logic [MW-1:0]        host_addr, cur_addr, d_addr, l_addr, u_addr;
  logic                 host_cell_ok;

  // memories
  logic          m_we;
  logic [MW-1:0] m_wa, m_ra;
  logic [15:0]   m_wd, m_rd;
  logic          rs_we, cs_we;
  logic [7:0]    rs_rd, cs_rd;

  always_comb begin
    rr   = len_eff(row_length) + ONE;
    cc   = len_eff(col_length) + ONE;
    j_s  = ad_r - i_r;
    ci   = i_r[IW-1:0];
    cj   = j_s[IW-1:0];
    be_n = (be_r + ONE < rr) ? be_r + ONE : rr;
    adl  = ad_r - cc + ONE;
    bs_n = (adl > bs_r) ? adl : bs_r;
  end

  assign host_cell_ok = (32'(host_row) <= 32'(MAX_LEN)) && (32'(host_col) <= 32'(MAX_LEN));
  assign host_addr    = cell_addr(IW'(host_row), IW'(host_col));
  assign cur_addr     = cell_addr(ci, cj);
  assign d_addr       = cell_addr(ci - IW'(1), cj - IW'(1));
  assign l_addr       = cell_addr(ci, cj - IW'(1));
  assign u_addr       = cell_addr(ci - IW'(1), cj);

  assign status.ad_done    = (ad_r >= rr + cc - ONE);
  assign status.band_empty = (bs_n >= be_n);
  assign status.at_end     = (i_r == be_r);
  assign status.boundary   = (i_r == ZERO) || (j_s == ZERO);

  // cell score from the three neighbours
  logic signed [17:0] cd, cl, cu, cbest;
  logic               cany;
  logic signed [15:0] cell_val;

  always_comb begin
    cd    = 18'(d_r) + ((rs_rd == cs_rd) ? 18'sd1 : 18'sd0);
    cl    = 18'(l_r) - 18'sd2;
    cu    = 18'($signed(m_rd)) - 18'sd2;
    cbest = '0;
    cany  = 1'b0;
    if (d_r != xda_pkg::PRUNED_MARK) begin
      cbest = cd;
      cany  = 1'b1;
    end
    if (l_r != xda_pkg::PRUNED_MARK && (!cany || cl > cbest)) begin
      cbest = cl;
      cany  = 1'b1;
    end
    if ($signed(m_rd) != xda_pkg::PRUNED_MARK && (!cany || cu > cbest)) begin
      cbest = cu;
      cany  = 1'b1;
    end
    if (cbest > xda_pkg::SCORE_HI) begin
      cbest = xda_pkg::SCORE_HI;
    end
    if (cbest < xda_pkg::SCORE_LO) begin
      cbest = xda_pkg::SCORE_LO;
    end
    cell_val = cany ? cbest[15:0] : xda_pkg::PRUNED_MARK;
  end

  // pruning decision in the second pass
  logic signed [17:0] limit, v18;
  logic               rb_set, do_prune, now_pruned;

  always_comb begin
    rb_set     = (rb_r != xda_pkg::PRUNED_MARK);
    limit      = 18'(rb_r) - 18'($signed({1'b0, x_threshold}));
    v18        = 18'($signed(m_rd));
    do_prune   = !status.boundary && rb_set && ($signed(m_rd) != xda_pkg::PRUNED_MARK)
                 && (v18 < limit);
    now_pruned = do_prune || ($signed(m_rd) == xda_pkg::PRUNED_MARK);
  end

  // band trimming and diagonal bounds
  logic signed [SW-1:0] f_eff, ib, dlo, dup, lo_n, up_n, tlo, tup, bs1, be1;
  logic                 fp, lp, lo_b_n, up_b_n;

  always_comb begin
    f_eff  = found_r ? f_r : be_r;
    fp     = (f_eff != bs_r);
    ib     = found_r ? lnp_r : be_r - ONE;
    lp     = found_r ? (lnp_r != be_r - ONE) : 1'b1;
    dlo    = TWO * f_eff - ad_r;
    dup    = TWO * ib - ad_r + TWO;
    lo_n   = (fp && (!lo_b_r || dlo > lo_r)) ? dlo : lo_r;
    up_n   = (lp && (!up_b_r || dup < up_r)) ? dup : up_r;
    lo_b_n = lo_b_r || fp;
    up_b_n = up_b_r || lp;
    tlo    = (lo_n + ad_r) >>> 1;
    tup    = (up_n + ad_r) >>> 1;
    bs1    = (lo_b_n && tlo > f_eff) ? tlo : f_eff;
    be1    = (up_b_n && tup < ib + ONE) ? tup : ib + ONE;
  end

  // memory ports
  always_comb begin
    m_we = 1'b0;
    m_wa = host_addr;
    m_wd = host_value;
    if (cmd.cmd == xda_pkg::CMD_CELL_WR) begin
      m_we = 1'b1;
      m_wa = cur_addr;
      m_wd = cell_val;
    end else if (cmd.cmd == xda_pkg::CMD_PRUNE_EV && do_prune) begin
      m_we = 1'b1;
      m_wa = cur_addr;
      m_wd = xda_pkg::PRUNED_MARK;
    end else if (host_accept && host_op == xda_pkg::OP_WRITE_CELL && host_cell_ok) begin
      m_we = 1'b1;
    end
    case (cmd.cmd)
      xda_pkg::CMD_RD_D:     m_ra = d_addr;
      xda_pkg::CMD_RD_L:     m_ra = l_addr;
      xda_pkg::CMD_RD_U:     m_ra = u_addr;
      xda_pkg::CMD_PRUNE_RD: m_ra = cur_addr;
      default:               m_ra = host_addr;
    endcase
  end

  assign rs_we = host_accept && host_op == xda_pkg::OP_LOAD_ROW
                 && (32'(host_row) < 32'(MAX_LEN));
  assign cs_we = host_accept && host_op == xda_pkg::OP_LOAD_COL
                 && (32'(host_col) < 32'(MAX_LEN));

  xda_ram #(.WIDTH(16), .DEPTH(DIM * DIM)) u_matrix (
    .clk     (clk),
    .wr_en   (m_we),
    .wr_addr (m_wa),
    .wr_data (m_wd),
    .rd_addr (m_ra),
    .rd_data (m_rd)
  );

  xda_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_row_sym (
    .clk     (clk),
    .wr_en   (rs_we),
    .wr_addr (SYW'(host_row)),
    .wr_data (host_symbol),
    .rd_addr (SYW'(ci - IW'(1))),
    .rd_data (rs_rd)
  );

  xda_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_col_sym (
    .clk     (clk),
    .wr_en   (cs_we),
    .wr_addr (SYW'(host_col)),
    .wr_data (host_symbol),
    .rd_addr (SYW'(cj - IW'(1))),
    .rd_data (cs_rd)
  );

  // sweep state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_r    <= ZERO;
      bs_r    <= ZERO;
      be_r    <= ZERO;
      i_r     <= ZERO;
      lo_r    <= ZERO;
      up_r    <= ZERO;
      lo_b_r  <= 1'b0;
      up_b_r  <= 1'b0;
      found_r <= 1'b0;
      f_r     <= ZERO;
      lnp_r   <= ZERO;
      rb_r    <= xda_pkg::PRUNED_MARK;
      rd_ok_r <= 1'b0;
    end else begin
      if (host_accept) begin
        rd_ok_r <= host_cell_ok;
      end
      case (cmd.cmd)
        xda_pkg::CMD_INIT: begin
          ad_r   <= ZERO;
          bs_r   <= ZERO;
          be_r   <= ZERO;
          lo_r   <= ZERO;
          up_r   <= ZERO;
          lo_b_r <= 1'b0;
          up_b_r <= 1'b0;
          rb_r   <= xda_pkg::PRUNED_MARK;
        end
        xda_pkg::CMD_AD_CHECK: begin
          bs_r <= bs_n;
          be_r <= be_n;
          i_r  <= bs_n;
        end
        xda_pkg::CMD_CELL_CHECK: begin
          if (status.at_end) begin
            i_r     <= bs_r;
            found_r <= 1'b0;
          end else if (status.boundary) begin
            i_r <= i_r + ONE;
          end
        end
        xda_pkg::CMD_CELL_WR: begin
          i_r <= i_r + ONE;
          if (cany && (rb_r == xda_pkg::PRUNED_MARK || cell_val > rb_r)) begin
            rb_r <= cell_val;
          end
        end
        xda_pkg::CMD_PRUNE_EV: begin
          i_r <= i_r + ONE;
          if (!now_pruned) begin
            if (!found_r) begin
              found_r <= 1'b1;
              f_r     <= i_r;
            end
            lnp_r <= i_r;
          end
        end
        xda_pkg::CMD_TRIM: begin
          bs_r   <= bs1;
          be_r   <= be1;
          lo_r   <= lo_n;
          up_r   <= up_n;
          lo_b_r <= lo_b_n;
          up_b_r <= up_b_n;
          ad_r   <= ad_r + ONE;
        end
        default: begin
        end
      endcase
    end
  end

  // neighbour capture, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.cmd == xda_pkg::CMD_RD_L) begin
      d_r <= $signed(m_rd);
    end
    if (cmd.cmd == xda_pkg::CMD_RD_U) begin
      l_r <= $signed(m_rd);
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.cmd == xda_pkg::CMD_FINISH || cmd.cmd == xda_pkg::CMD_READ_RESP) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd == xda_pkg::CMD_FINISH) begin
      out_kind    <= xda_pkg::KIND_RUN;
      out_score   <= '0;
      out_pruned  <= 1'b0;
      out_best    <= rb_r;
      out_stopped <= cmd.stopped;
    end else if (cmd.cmd == xda_pkg::CMD_READ_RESP) begin
      out_kind    <= xda_pkg::KIND_READ;
      out_score   <= rd_ok_r ? $signed(m_rd) : 16'sd0;
      out_pruned  <= rd_ok_r && ($signed(m_rd) == xda_pkg::PRUNED_MARK);
      out_best    <= '0;
      out_stopped <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/xdrop_antidiagonal_alignment.sv @@
// banded global aligner with score pruning, swept one antidiagonal at a time
// input stream: in_tuser carries the operation (load row symbol, load column
//   symbol, write cell, run, read cell), in_tdata the indexes, symbol and value
// result stream: one transfer per run (kind 0, best score, early-stop flag)
//   and per cell read (kind 1, score, pruned flag); other operations give none
// loads and cell writes are taken back to back
// a cell read passes the read state, then its result is registered for output
// a run keeps in_tready low until the sweep ends: per antidiagonal a band
//   set-up, a cell pass (check; off row 0 and column 0 read diagonal, left
//   and upper on the single score memory read port, then write), a pruning
//   pass (read, then evaluate), pass ends and trimming; plus start and finish
// results sit in an output register; while the receiver stalls, new items are
//   refused only once that register holds a transfer that is not taken yet
// rst_n (synchronous, active low) empties the output register, stops any run
//   and puts the registers back to 64, 64 and 10; symbol and score memories
//   keep their contents and must be written before they are read
// configuration writes on the cfg_ port are meant for an idle block
module xdrop_antidiagonal_alignment #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row_index, col_index, symbol, cell_value
  input  logic [2:0]  in_tuser,   // operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // score, pruned, best_score, stopped_early
  output logic        out_tuser,  // kind
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [6:0]  row_len_r, col_len_r;
  logic [14:0] x_thr_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= xda_pkg::ROW_LEN_RESET;
      col_len_r <= xda_pkg::COL_LEN_RESET;
      x_thr_r   <= xda_pkg::X_THR_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        xda_pkg::REG_ROW_LEN: row_len_r <= cfg_pwdata[6:0];
        xda_pkg::REG_COL_LEN: col_len_r <= cfg_pwdata[6:0];
        xda_pkg::REG_X_THR:   x_thr_r   <= cfg_pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      xda_pkg::REG_ROW_LEN: cfg_prdata = {25'd0, row_len_r};
      xda_pkg::REG_COL_LEN: cfg_prdata = {25'd0, col_len_r};
      xda_pkg::REG_X_THR:   cfg_prdata = {17'd0, x_thr_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // control and status between sequencer and datapath
  xda_pkg::ctrl_cmd_t  cmd;
  xda_pkg::dp_status_t status;
  logic                idle;
  logic                in_accept;

  // block idle, and out register free or its transfer completes this cycle
  assign in_tready = idle && (!out_tvalid || out_tready);
  assign in_accept = in_tvalid && in_tready;

  xda_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .host_accept (in_accept),
    .host_op     (in_tuser),
    .status      (status),
    .cmd         (cmd),
    .idle        (idle)
  );

  logic signed [15:0] res_score, res_best;
  logic               res_kind, res_pruned, res_stopped;

  xda_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .host_accept (in_accept),
    .host_op     (in_tuser),
    .host_row    (in_tdata[6:0]),
    .host_col    (in_tdata[13:7]),
    .host_symbol (in_tdata[21:14]),
    .host_value  ($signed(in_tdata[37:22])),
    .row_length  (row_len_r),
    .col_length  (col_len_r),
    .x_threshold (x_thr_r),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_kind    (res_kind),
    .out_score   (res_score),
    .out_pruned  (res_pruned),
    .out_best    (res_best),
    .out_stopped (res_stopped)
  );

  // result fields packed from the lowest bit up
  assign out_tdata = {6'd0, res_stopped, res_best, res_pruned, res_score};
  assign out_tuser = res_kind;

endmodule
